// File: rtl/bgi_pkg.sv
// Shared types and fixed-point constants for the bicubic grid interpolator.
`default_nettype none

package bgi_pkg;

  // Field widths
  localparam int unsigned PIX_W  = 16;  // Q1.15 cell / result
  localparam int unsigned FRAC_W = 16;  // Q0.16 offset
  localparam int unsigned A_W    = 15;  // Q3.12 kernel parameter
  localparam int unsigned A_FRAC = 12;  // fraction bits of the kernel parameter
  localparam int unsigned WGT_FRAC = 16;  // fraction bits of a kernel weight

  // Datapath widths
  localparam int unsigned MUL_W  = 25;         // shared multiplier operand
  localparam int unsigned PROD_W = 2 * MUL_W;  // registered product
  localparam int unsigned ACC_W  = PROD_W;     // wide sums
  localparam int unsigned VAL_W  = 24;         // weights, row sums, polynomial

  localparam logic signed [A_W-1:0] KERNEL_A_RESET = -15'sd2048;  // -0.5
  localparam logic [PIX_W-1:0] PROB_ONE  = PIX_W'(1) << (PIX_W - 1);
  localparam logic [PIX_W-1:0] PROB_HALF = PIX_W'(1) << (PIX_W - 2);
  localparam logic [4:0]       ALL_UNSEEN = 5'd16;

  // One row of the window
  typedef struct packed {
    logic [PIX_W-1:0]  cell_0;
    logic [PIX_W-1:0]  cell_1;
    logic [PIX_W-1:0]  cell_2;
    logic [PIX_W-1:0]  cell_3;
    logic [3:0]        unseen_mask;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    logic              last_row;
  } in_item_t;

  // One interpolated result
  typedef struct packed {
    logic [PIX_W-1:0] probability;
    logic             not_observed;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/bgi_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module bgi_mul (
  input  logic                               clk_i,
  input  logic signed [bgi_pkg::MUL_W-1:0]   a_i,
  input  logic signed [bgi_pkg::MUL_W-1:0]   b_i,
  output logic signed [bgi_pkg::PROD_W-1:0]  p_o
);
  import bgi_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // one product per cycle, available the cycle after issue
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/bgi_row_store.sv
// Row store: three held rows plus the last row, row count and unseen tally.
`default_nettype none

module bgi_row_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  bgi_pkg::in_item_t           item_i,
  input  logic [1:0]                  rd_row_i,
  input  logic [1:0]                  rd_col_i,
  output logic [bgi_pkg::PIX_W-1:0]   rd_data_o,
  output logic [4:0]                  unseen_o
);
  import bgi_pkg::*;

  localparam int unsigned HELD_ROWS = 3;
  localparam int unsigned ROWS      = 4;
  localparam int unsigned COLS      = 4;

  logic [PIX_W-1:0]          store_q [ROWS][COLS];
  logic [PIX_W-1:0]          rd_data_q;
  logic [1:0]                rows_taken_q, rows_taken_d;
  logic [4:0]                tally_q, tally_d;
  logic [2:0]                row_unseen;
  logic [COLS-1:0][PIX_W-1:0] row_cells;
  logic                      wr_en;
  logic [1:0]                wr_row;

  assign row_cells = {item_i.cell_3, item_i.cell_2, item_i.cell_1, item_i.cell_0};

  // unseen cells of the incoming row, added to what the held rows had
  assign row_unseen = {2'b0, item_i.unseen_mask[0]} + {2'b0, item_i.unseen_mask[1]}
                    + {2'b0, item_i.unseen_mask[2]} + {2'b0, item_i.unseen_mask[3]};
  assign unseen_o = tally_q + {2'b0, row_unseen};

  // a held row goes to the next free slot, the last row to the top slot;
  // rows past the third are dropped
  assign wr_en  = take_i && (item_i.last_row || (rows_taken_q < 2'(HELD_ROWS)));
  assign wr_row = item_i.last_row ? 2'(ROWS - 1) : rows_taken_q;

  always_comb begin
    rows_taken_d = rows_taken_q;
    tally_d      = tally_q;
    if (take_i) begin
      if (item_i.last_row) begin
        rows_taken_d = '0;
        tally_d      = '0;
      end else if (rows_taken_q < 2'(HELD_ROWS)) begin
        rows_taken_d = rows_taken_q + 2'd1;
        tally_d      = unseen_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_taken_q <= '0;
      tally_q      <= '0;
    end else begin
      rows_taken_q <= rows_taken_d;
      tally_q      <= tally_d;
    end
  end

  // cell storage, no reset: every entry is written before it is read;
  // the read data is registered, so the data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int i = 0; i < COLS; i++) begin
        store_q[wr_row][i] <= row_cells[i];
      end
    end
    rd_data_q <= store_q[rd_row_i][rd_col_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/bicubic_grid_interpolator.sv
// Top level: sequencer around one shared multiplier for 4x4 bicubic interpolation.
//
//   channel  signals                           transfer when
//   -------  --------------------------------  ---------------------------
//   in       in_valid_i in_stall_o in_data_i   in_valid_i && !in_stall_o
//   out      out_valid_o out_stall_i out_data_o out_valid_o && !out_stall_i
//   cfg      cfg_we_i cfg_wdata_i              cfg_we_i
//
// A row without last_row is taken by the row store. A last row starts the
// sequence on the shared multiplier: 8 weights of 5 steps each, then the row
// sums, the column sum and a finish step that loads the clamped result;
// a fully unobserved window goes straight to the finish step. in_stall_o is
// high from the last-row transfer until the result is loaded. A result that
// waits on out_stall_i does not block further held rows, only the finish.
// Reset clears the row count, unseen tally, sequencer and output valid.
`default_nettype none

module bicubic_grid_interpolator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bgi_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bgi_pkg::out_item_t         out_data_o,
  input  logic                       cfg_we_i,
  input  logic [bgi_pkg::A_W-1:0]    cfg_wdata_i
);
  import bgi_pkg::*;

  localparam int unsigned D_W    = FRAC_W + 2;  // distance, Q2.F
  localparam int unsigned D2_W   = FRAC_W + 3;
  localparam int unsigned D3_W   = FRAC_W + 4;
  localparam int unsigned NUM_W  = 8;
  localparam int unsigned NUM_CELLS = 16;
  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned RND_SH = FRAC_W + A_FRAC - WGT_FRAC;
  localparam logic [D_W-1:0] ONE_D = D_W'(1) << FRAC_W;
  localparam logic [D_W-1:0] TWO_D = D_W'(2) << FRAC_W;
  localparam logic signed [ACC_W-1:0] W_RND  = ACC_W'(1) << (RND_SH - 1);
  localparam logic signed [ACC_W-1:0] NEAR_C = (ACC_W'(1) << (FRAC_W + A_FRAC)) + W_RND;
  localparam logic signed [ACC_W-1:0] FOUR_D = ACC_W'(4) << FRAC_W;
  localparam logic signed [ACC_W-1:0] S_RND  = ACC_W'(1) << (WGT_FRAC - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_WGT, ST_SUM, ST_TOT, ST_FIN} state_e;
  typedef enum logic [2:0] {WS_SQ, WS_CUBE, WS_POLY, WS_SCALE, WS_ROUND} wstep_e;

  state_e              state_q, state_d;
  wstep_e              wstep_q, wstep_d;
  logic [2:0]          widx_q, widx_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                nobs_q, nobs_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic signed [A_W-1:0] kernel_a_q, kernel_a_d;

  logic [FRAC_W-1:0]   frac_x_q, frac_y_q;
  logic [D2_W-1:0]     d2_q, d2_d;
  logic signed [VAL_W-1:0] p_q, p_d;
  logic signed [ACC_W-1:0] c_q, c_d;
  logic signed [VAL_W-1:0] w_q [NUM_W];
  logic signed [VAL_W-1:0] w_d [NUM_W];
  logic signed [VAL_W-1:0] rowval_q [NUM_ROWS];
  logic signed [VAL_W-1:0] rowval_d [NUM_ROWS];
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic                in_take, last_take;
  logic [4:0]          rs_unseen;
  logic [PIX_W-1:0]    cell_rd;
  logic [FRAC_W-1:0]   t_sel;
  logic [D_W-1:0]      d;
  logic [D2_W-1:0]     d2_now;
  logic [D3_W-1:0]     d3_now;
  logic signed [ACC_W-1:0] d_s, d2_s, d3_s, poly, wsum, wshift, acc_base, res_wide;
  logic [3:0]          elem;
  logic [2:0]          w_rd;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [PIX_W-1:0]    res_clamped;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign last_take  = in_take && in_data_i.last_row;

  // store read is registered: address from the next count, data with cnt_q
  bgi_row_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_take),
    .item_i    (in_data_i),
    .rd_row_i  (cnt_d[3:2]),
    .rd_col_i  (cnt_d[1:0]),
    .rd_data_o (cell_rd),
    .unseen_o  (rs_unseen)
  );

  bgi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  // distance for the current weight: 1+t, t, 1-t, 2-t
  assign t_sel = widx_q[2] ? frac_y_q : frac_x_q;
  always_comb begin
    case (widx_q[1:0])
      2'd0:    d = ONE_D + D_W'(t_sel);
      2'd1:    d = D_W'(t_sel);
      2'd2:    d = ONE_D - D_W'(t_sel);
      default: d = TWO_D - D_W'(t_sel);
    endcase
  end

  assign d2_now = prod_q[FRAC_W +: D2_W];
  assign d3_now = prod_q[FRAC_W +: D3_W];
  assign d_s    = ACC_W'(d);
  assign d2_s   = ACC_W'(d2_q);
  assign d3_s   = ACC_W'(d3_now);
  // far branch polynomial: d^3 - 5 d^2 + 8 d - 4
  assign poly   = d3_s - (d2_s <<< 2) - d2_s + (d_s <<< 3) - FOUR_D;

  assign wsum   = prod_q + c_q;
  assign wshift = wsum >>> RND_SH;

  // element whose product lands this cycle in the sum phases
  assign elem = 4'(cnt_q - 5'd1);
  assign acc_base = (elem[1:0] == 2'd0) ? S_RND : acc_q;
  assign w_rd = {state_q == ST_TOT, cnt_q[1:0]};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_WGT: begin
        case (wstep_q)
          WS_SQ: begin
            mul_a = MUL_W'(d);
            mul_b = MUL_W'(d);
          end
          WS_CUBE: begin
            mul_a = MUL_W'(d2_now);
            mul_b = MUL_W'(d);
          end
          WS_SCALE: begin
            mul_a = MUL_W'(kernel_a_q);
            mul_b = MUL_W'(p_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_SUM: begin
        mul_a = MUL_W'(w_q[w_rd]);
        mul_b = MUL_W'(cell_rd);
      end
      ST_TOT: begin
        mul_a = MUL_W'(w_q[w_rd]);
        mul_b = MUL_W'(rowval_q[cnt_q[1:0]]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    d2_d     = d2_q;
    p_d      = p_q;
    c_d      = c_q;
    w_d      = w_q;
    rowval_d = rowval_q;
    acc_d    = acc_q;
    case (state_q)
      ST_WGT: begin
        case (wstep_q)
          WS_CUBE: d2_d = d2_now;
          WS_POLY: begin
            if (d <= ONE_D) begin
              p_d = VAL_W'(d3_s - d2_s);
              c_d = (d3_s <<< 13) - (d2_s <<< 13) - (d2_s <<< 12) + NEAR_C;
            end else if (d <= TWO_D) begin
              p_d = VAL_W'(poly);
              c_d = W_RND;
            end else begin
              p_d = '0;
              c_d = W_RND;
            end
          end
          WS_ROUND: w_d[widx_q] = VAL_W'(wshift);
          default: d2_d = d2_q;
        endcase
      end
      ST_SUM: begin
        if (cnt_q != 5'd0) begin
          acc_d = acc_base + prod_q;
          if (elem[1:0] == 2'(NUM_ROWS - 1)) begin
            rowval_d[elem[3:2]] = VAL_W'(acc_d >>> WGT_FRAC);
          end
        end
      end
      ST_TOT: begin
        if (cnt_q != 5'd0) begin
          acc_d = acc_base + prod_q;
        end
      end
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (last_take) begin
      frac_x_q <= in_data_i.frac_x;
      frac_y_q <= in_data_i.frac_y;
    end
    d2_q     <= d2_d;
    p_q      <= p_d;
    c_q      <= c_d;
    w_q      <= w_d;
    rowval_q <= rowval_d;
    acc_q    <= acc_d;
  end

  // final round and clamp to 0..1
  assign res_wide = acc_q >>> WGT_FRAC;
  always_comb begin
    if (res_wide[ACC_W-1]) begin
      res_clamped = '0;
    end else if (res_wide[ACC_W-2:0] > (ACC_W-1)'(PROB_ONE)) begin
      res_clamped = PROB_ONE;
    end else begin
      res_clamped = res_wide[PIX_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    wstep_d     = wstep_q;
    widx_d      = widx_q;
    cnt_d       = cnt_q;
    nobs_d      = nobs_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    kernel_a_d  = kernel_a_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      kernel_a_d = cfg_wdata_i;
    end
    case (state_q)
      ST_IDLE: begin
        if (last_take) begin
          widx_d  = '0;
          wstep_d = WS_SQ;
          cnt_d   = '0;
          nobs_d  = (rs_unseen == ALL_UNSEEN);
          state_d = (rs_unseen == ALL_UNSEEN) ? ST_FIN : ST_WGT;
        end
      end
      ST_WGT: begin
        case (wstep_q)
          WS_SQ:    wstep_d = WS_CUBE;
          WS_CUBE:  wstep_d = WS_POLY;
          WS_POLY:  wstep_d = WS_SCALE;
          WS_SCALE: wstep_d = WS_ROUND;
          WS_ROUND: begin
            wstep_d = WS_SQ;
            widx_d  = widx_q + 3'd1;
            if (widx_q == 3'(NUM_W - 1)) begin
              cnt_d   = '0;
              state_d = ST_SUM;
            end
          end
          default: wstep_d = WS_SQ;
        endcase
      end
      ST_SUM: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NUM_CELLS)) begin
          cnt_d   = '0;
          state_d = ST_TOT;
        end
      end
      ST_TOT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NUM_ROWS)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (nobs_q) begin
            out_d.probability  = PROB_HALF;
            out_d.not_observed = 1'b1;
          end else begin
            out_d.probability  = res_clamped;
            out_d.not_observed = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wstep_q     <= WS_SQ;
      widx_q      <= '0;
      cnt_q       <= '0;
      nobs_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      kernel_a_q  <= KERNEL_A_RESET;
    end else begin
      state_q     <= state_d;
      wstep_q     <= wstep_d;
      widx_q      <= widx_d;
      cnt_q       <= cnt_d;
      nobs_q      <= nobs_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      kernel_a_q  <= kernel_a_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_half_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.not_observed |-> out_data_o.probability == PROB_HALF)
    else $error("unobserved result is not one half");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.probability <= PROB_ONE)
    else $error("result above one");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_row |=> in_stall_o)
    else $error("last row transfer did not start the sequence");

  a_row_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.last_row |=> !in_stall_o)
    else $error("held row transfer stalled the input");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result loaded outside the finish step");

endmodule

`default_nettype wire
